// ----- sv/ncrm_pkg.sv -----
// Package for the nearest-centroid radius match block.
// Holds the request and result payload types, request codes and register indexes.
// No dependencies.
`default_nettype none

package ncrm_pkg;

  // Request type codes carried in the req_type field.
  localparam logic [1:0] REQ_CENTRE = 2'd0;
  localparam logic [1:0] REQ_RADIUS = 2'd1;
  localparam logic [1:0] REQ_POINT  = 2'd2;

  // Register indexes, taken from word address bit 2.
  localparam logic REG_DIMS     = 1'b0;
  localparam logic REG_CLUSTERS = 1'b1;

  localparam int SUM_W   = 48;
  localparam int COORD_W = 16;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         cluster_index;
    logic [4:0]         coord_index;
    logic [COORD_W-1:0] coord_value;
    logic [SUM_W-1:0]   radius_sq;
    logic [31:0]        point_id;
    logic               last;
  } ncrm_in_t;

  typedef struct packed {
    logic [31:0]      result_point_id;
    logic             found;
    logic [5:0]       matched_cluster;
    logic [SUM_W-1:0] distance_sq;
    logic             within_radius;
  } ncrm_out_t;

  // Control of one issue slot into the accumulate unit.
  typedef struct packed {
    logic valid;
    logic live;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/ncrm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ncrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/ncrm_mac.sv -----
// Shared accumulate unit: absolute difference, square, saturating 48-bit add.
// Two register stages; depends on ncrm_pkg.
`default_nettype none

module ncrm_mac #(
  parameter int IDX_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ncrm_pkg::mac_ctrl_t      issue,
  input  wire logic [IDX_W-1:0]         issue_idx,
  input  wire logic [15:0]              point_val,
  input  wire logic [15:0]              centre_rd,
  input  wire logic [47:0]              psum_rd,
  output logic                          wr_en,
  output logic      [IDX_W-1:0]         wr_idx,
  output logic      [47:0]              wr_data,
  output logic                          busy
);

  import ncrm_pkg::*;

  // Stage 1 lines up with the registered RAM data.
  logic             v1;
  logic             live1;
  logic [IDX_W-1:0] idx1;
  // Stage 2 holds the square and the old sum.
  logic             v2;
  logic [IDX_W-1:0] idx2;
  logic [31:0]      sq2;
  logic [47:0]      acc2;

  logic [15:0] diff;
  logic [48:0] sum;

  always_comb begin
    diff = (point_val >= centre_rd) ? (point_val - centre_rd) : (centre_rd - point_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue.valid;
      v2 <= v1;
    end
    live1 <= issue.live;
    idx1  <= issue_idx;
    idx2  <= idx1;
    sq2   <= 32'(diff) * 32'(diff);
    // A sum not yet written during this point counts as zero.
    acc2  <= live1 ? psum_rd : '0;
  end

  always_comb begin
    sum     = {1'b0, acc2} + 49'(sq2);
    wr_en   = v2;
    wr_idx  = idx2;
    wr_data = sum[48] ? '1 : sum[47:0];
    busy    = v1 | v2;
  end

endmodule

`default_nettype wire

// ----- sv/nearest_centroid_radius_match_top.sv -----
// Top level of the nearest-centroid radius match block.
// Depends on ncrm_pkg, ncrm_ram and ncrm_mac.
//
// Usage. Items arrive on the item channel (item_valid, item_ready, item) and results
// leave on the result channel (result_valid, result_ready, result); a transaction
// completes at a rising edge where valid and ready are both high. Centre coordinate
// and squared radius writes are stored in the cycle they are accepted, and the block
// is ready again on the next cycle. A point coordinate with an index below the
// effective dimension count adds its squared difference to the running sum of every
// cluster in use: one cluster per cycle through the shared accumulate unit, after which
// the unit drains. A coordinate flagged last then scans the sums, one cluster per cycle,
// and reads the winner's radius before the result is registered.
// The result sits in an output register, so a stalled receiver only holds the block
// once a second result is finished; until then items keep being accepted.
// Reset is synchronous and active high. It restores dims_in_use to 22 and
// clusters_in_use to 1 and marks every running sum as zero through a fill count;
// there is no clearing pass. Centre and radius tables hold nothing defined until
// written. Registers sit on a small APB-style port, with pready tied high.
`default_nettype none

module nearest_centroid_radius_match_top #(
  parameter int MAX_CLUSTERS = 64,
  parameter int MAX_DIMS     = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire ncrm_pkg::ncrm_in_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output ncrm_pkg::ncrm_out_t      result,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  import ncrm_pkg::*;

  localparam int CL_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CN_W = $clog2(MAX_CLUSTERS + 1);
  localparam int CA_W = (MAX_CLUSTERS * MAX_DIMS > 1) ? $clog2(MAX_CLUSTERS * MAX_DIMS) : 1;
  localparam int ND_W = $clog2(MAX_DIMS + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ACC      = 7'b0000010,
    S_DRAIN    = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_SCAN_END = 7'b0010000,
    S_RAD      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [5:0] dims_in_use;
  logic [6:0] clusters_in_use;

  // Effective counts after saturation to the table size.
  logic [ND_W-1:0] nd_eff;
  logic [CN_W-1:0] nc_eff;
  logic [12:0]     nd_sq;
  logic [47:0]     threshold;

  // Working registers of the current point.
  logic [CL_W-1:0] cnt;
  logic [CA_W-1:0] caddr;
  logic [15:0]     pt_val;
  logic [31:0]     pt_id;
  logic            pt_last;
  logic [CN_W-1:0] live_count;
  logic [47:0]     best;
  logic [CL_W-1:0] best_idx;
  logic            best_found;

  // Scan compare stage, aligned with the registered sum read.
  logic            scan_v1;
  logic            scan_live1;
  logic [CL_W-1:0] scan_idx1;
  logic [47:0]     scan_cur;

  logic accept;
  logic cfg_write;
  logic cnt_last;
  logic cnt_live;
  logic cl_ok;
  logic co_ok;
  logic co_used;
  logic load_result;

  logic            centre_we;
  logic [CA_W-1:0] centre_waddr;
  logic [15:0]     centre_rd;
  logic            radius_we;
  logic [47:0]     radius_rd;
  logic [47:0]     psum_rd;

  mac_ctrl_t       mac_issue;
  logic            mac_wr_en;
  logic [CL_W-1:0] mac_wr_idx;
  logic [47:0]     mac_wr_data;
  logic            mac_busy;

  // ---------------------------------------------------------------------------
  // Register port. Word address bit 2 selects the register.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    if (paddr[2] == REG_CLUSTERS) begin
      prdata = 32'(clusters_in_use);
    end else begin
      prdata = 32'(dims_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use     <= 6'd22;
      clusters_in_use <= 7'd1;
    end else if (cfg_write) begin
      if (paddr[2] == REG_CLUSTERS) begin
        clusters_in_use <= pwdata[6:0];
      end else begin
        dims_in_use <= pwdata[5:0];
      end
    end
  end

  always_comb begin
    nd_eff    = (32'(dims_in_use) > MAX_DIMS) ? ND_W'(MAX_DIMS) : ND_W'(dims_in_use);
    nc_eff    = (32'(clusters_in_use) > MAX_CLUSTERS) ? CN_W'(MAX_CLUSTERS)
                                                      : CN_W'(clusters_in_use);
    nd_sq     = 13'(nd_eff) * 13'(nd_eff);
    // A cluster only counts as found when its distance is below dims squared shifted up by 32 bits.
    threshold = {3'b000, nd_sq, 32'h0000_0000};
  end

  // ---------------------------------------------------------------------------
  // Item decode.
  // ---------------------------------------------------------------------------
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid & item_ready;

  always_comb begin
    cl_ok        = 32'(item.cluster_index) < MAX_CLUSTERS;
    co_ok        = 32'(item.coord_index) < MAX_DIMS;
    co_used      = 32'(item.coord_index) < 32'(nd_eff);
    centre_we    = accept && (item.req_type == REQ_CENTRE) && cl_ok && co_ok;
    radius_we    = accept && (item.req_type == REQ_RADIUS) && cl_ok;
    centre_waddr = CA_W'(32'(item.cluster_index) * MAX_DIMS + 32'(item.coord_index));
    cnt_last     = (CN_W'(cnt) + CN_W'(1)) == nc_eff;
    cnt_live     = CN_W'(cnt) < live_count;
    load_result  = (state == S_DONE) && (!result_valid || result_ready);
  end

  // ---------------------------------------------------------------------------
  // Tables and the shared accumulate unit.
  // ---------------------------------------------------------------------------
  ncrm_ram #(.WIDTH(16), .DEPTH(MAX_CLUSTERS * MAX_DIMS)) u_centre_ram (
    .clk   (clk),
    .we    (centre_we),
    .waddr (centre_waddr),
    .wdata (item.coord_value),
    .raddr (caddr),
    .rdata (centre_rd)
  );

  ncrm_ram #(.WIDTH(48), .DEPTH(MAX_CLUSTERS)) u_radius_ram (
    .clk   (clk),
    .we    (radius_we),
    .waddr (CL_W'(item.cluster_index)),
    .wdata (item.radius_sq),
    .raddr (best_idx),
    .rdata (radius_rd)
  );

  ncrm_ram #(.WIDTH(48), .DEPTH(MAX_CLUSTERS)) u_psum_ram (
    .clk   (clk),
    .we    (mac_wr_en),
    .waddr (mac_wr_idx),
    .wdata (mac_wr_data),
    .raddr (cnt),
    .rdata (psum_rd)
  );

  always_comb begin
    mac_issue.valid = (state == S_ACC);
    mac_issue.live  = cnt_live;
  end

  ncrm_mac #(.IDX_W(CL_W)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (mac_issue),
    .issue_idx (cnt),
    .point_val (pt_val),
    .centre_rd (centre_rd),
    .psum_rd   (psum_rd),
    .wr_en     (mac_wr_en),
    .wr_idx    (mac_wr_idx),
    .wr_data   (mac_wr_data),
    .busy      (mac_busy)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: accumulate pass, drain, minimum scan, radius read, result.
  // ---------------------------------------------------------------------------
  assign scan_cur = scan_live1 ? psum_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      live_count   <= '0;
      result_valid <= 1'b0;
      scan_v1      <= 1'b0;
    end else begin
      scan_v1 <= (state == S_SCAN);
      // A new result may replace one that leaves in the same cycle.
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (item.req_type == REQ_POINT)) begin
            if (co_used && (nc_eff != '0)) begin
              state <= S_ACC;
            end else if (item.last) begin
              state <= (nc_eff == '0) ? S_RAD : S_SCAN;
            end
          end
        end
        S_ACC: begin
          if (cnt_last) begin
            state      <= S_DRAIN;
            live_count <= (nc_eff > live_count) ? nc_eff : live_count;
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            if (pt_last) begin
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          if (cnt_last) begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          state <= S_RAD;
        end
        S_RAD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_result) begin
            state      <= S_IDLE;
            // Every running sum returns to zero for the next point.
            live_count <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    scan_live1 <= cnt_live;
    scan_idx1  <= cnt;
    if (accept) begin
      pt_val  <= item.coord_value;
      pt_id   <= item.point_id;
      pt_last <= item.last;
      caddr   <= CA_W'(item.coord_index);
      cnt     <= '0;
    end else if (state == S_ACC) begin
      cnt   <= cnt + CL_W'(1);
      caddr <= caddr + CA_W'(MAX_DIMS);
    end else if (state == S_SCAN) begin
      cnt <= cnt + CL_W'(1);
    end else begin
      cnt <= '0;
    end
    // The search starts from the dims-squared bound before each scan.
    if (state == S_IDLE || state == S_DRAIN) begin
      best       <= threshold;
      best_idx   <= '0;
      best_found <= 1'b0;
    end else if (scan_v1 && (scan_cur < best)) begin
      // Strictly smaller, so the lowest index wins a tie.
      best       <= scan_cur;
      best_idx   <= scan_idx1;
      best_found <= 1'b1;
    end
    if (load_result) begin
      result.result_point_id <= pt_id;
      result.found           <= best_found;
      result.matched_cluster <= best_found ? 6'(best_idx) : 6'd0;
      result.distance_sq     <= best_found ? best : '0;
      result.within_radius   <= best_found && (best <= radius_rd);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(live_count) <= MAX_CLUSTERS)
    else $error("running sum fill count exceeds table size");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mac_busy)
    else $error("accumulate unit busy while sequencer idle");

  a_result_clears_sums: assert property (@(posedge clk) disable iff (rst)
    load_result |=> (result_valid && (live_count == '0)))
    else $error("result load did not clear running sums");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |->
      ((result.distance_sq == '0) && !result.within_radius && (result.matched_cluster == '0)))
    else $error("not-found result carries nonzero fields");

endmodule

`default_nettype wire

// ----- bench/ncrm_bench_pkg.sv -----
// Scoreboard for the nearest-centroid radius match block: a cycle-free predictor of its tables,
// running sums and registers, plus the queue of expected results and the result checker.
// Depends on ncrm_pkg for the payload types, request codes and register indexes.
`default_nettype none

package ncrm_bench_pkg;
  import ncrm_pkg::*;

  // The fourth request code carries no operation; the block drops it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int N_CLUSTERS   = 64;
  localparam int N_DIMS       = 32;
  localparam int REPORT_LIMIT = 10;

  class centroid_match_scoreboard;
    logic [15:0] centre_mem [N_CLUSTERS][N_DIMS];
    logic [47:0] radius_mem [N_CLUSTERS];
    logic [47:0] dist_acc   [N_CLUSTERS];
    logic [5:0]  dims_reg;
    logic [6:0]  clusters_reg;
    ncrm_out_t   expected_matches [$];
    int          failures;

    function new();
      dims_reg     = 6'd22;
      clusters_reg = 7'd1;
      foreach (centre_mem[c, d]) centre_mem[c][d] = '0;
      foreach (radius_mem[c]) begin
        radius_mem[c] = '0;
        dist_acc[c]   = '0;
      end
      failures = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == REG_DIMS) begin
        dims_reg = value[5:0];
      end else begin
        clusters_reg = value[6:0];
      end
    endfunction

    function int active_dims();
      return (int'(dims_reg) > N_DIMS) ? N_DIMS : int'(dims_reg);
    endfunction

    function int active_clusters();
      return (int'(clusters_reg) > N_CLUSTERS) ? N_CLUSTERS : int'(clusters_reg);
    endfunction

    function int pending_count();
      return expected_matches.size();
    endfunction

    // Applies one accepted request transaction to the predicted state.
    function void note_item(ncrm_in_t it);
      int          nd;
      int          nc;
      int          c;
      int          best_idx;
      logic [15:0] cv;
      logic [15:0] diff;
      logic [31:0] sq;
      logic [48:0] sum;
      logic [63:0] best;
      bit          hit;
      ncrm_out_t   res;
      nd = active_dims();
      nc = active_clusters();
      case (it.req_type)
        REQ_CENTRE: begin
          centre_mem[it.cluster_index][it.coord_index] = it.coord_value;
        end
        REQ_RADIUS: begin
          radius_mem[it.cluster_index] = it.radius_sq;
        end
        REQ_POINT: begin
          if (int'(it.coord_index) < nd) begin
            for (c = 0; c < nc; c++) begin
              cv   = centre_mem[c][it.coord_index];
              diff = (it.coord_value >= cv) ? it.coord_value - cv : cv - it.coord_value;
              sq   = 32'(diff) * 32'(diff);
              sum  = {1'b0, dist_acc[c]} + {17'd0, sq};
              dist_acc[c] = sum[48] ? {48{1'b1}} : sum[47:0];
            end
          end
          if (it.last) begin
            // Threshold is dims squared in Q32.32; the scan keeps the first strict minimum.
            best     = 64'(nd * nd) << 32;
            best_idx = 0;
            hit      = 1'b0;
            for (c = 0; c < nc; c++) begin
              if ({16'd0, dist_acc[c]} < best) begin
                best     = {16'd0, dist_acc[c]};
                best_idx = c;
                hit      = 1'b1;
              end
            end
            res.result_point_id = it.point_id;
            res.found           = hit;
            res.matched_cluster = hit ? 6'(best_idx) : 6'd0;
            res.distance_sq     = hit ? best[47:0] : 48'd0;
            res.within_radius   = hit && (best[47:0] <= radius_mem[best_idx]);
            expected_matches.push_back(res);
            for (c = 0; c < N_CLUSTERS; c++) dist_acc[c] = '0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void check_result(ncrm_out_t got);
      ncrm_out_t want;
      bit        bad;
      if (expected_matches.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("unexpected result: id %h found %0b cluster %0d dist %h within %0b",
                   got.result_point_id, got.found, got.matched_cluster, got.distance_sq,
                   got.within_radius);
        end
        return;
      end
      want = expected_matches.pop_front();
      bad  = (got.result_point_id !== want.result_point_id) ||
             (got.found !== want.found) ||
             (got.matched_cluster !== want.matched_cluster) ||
             (got.distance_sq !== want.distance_sq) ||
             (got.within_radius !== want.within_radius);
      if (bad) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("wrong result: expected id %h found %0b cluster %0d dist %h within %0b",
                   want.result_point_id, want.found, want.matched_cluster, want.distance_sq,
                   want.within_radius);
          $display("              actual   id %h found %0b cluster %0d dist %h within %0b",
                   got.result_point_id, got.found, got.matched_cluster, got.distance_sq,
                   got.within_radius);
        end
      end
    endfunction
  endclass

endpackage

`default_nettype wire

// ----- bench/nearest_centroid_radius_match_top_test.sv -----
// Testbench top for the nearest-centroid radius match block: directed and random requests,
// random idling on both channels, register writes between phases, checks against a predictor.
// Depends on ncrm_pkg, ncrm_bench_pkg and the nearest_centroid_radius_match_top RTL.
`default_nettype none

module nearest_centroid_radius_match_top_test;
  import ncrm_pkg::*;
  import ncrm_bench_pkg::*;

  // Percentage of cycles in which a side idles while stalls are enabled.
  localparam int STALL_PCT      = 24;
  // A last coordinate over the full cluster table accumulates and then scans all 64 clusters,
  // so this covers any work still in flight after the final expected result.
  localparam int SETTLE_CYCLES  = 300;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 650;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  ncrm_in_t    item;
  logic        result_valid;
  logic        result_ready;
  ncrm_out_t   result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  centroid_match_scoreboard sb;

  // Which centre coordinates and radii have been loaded. Point coordinates and last flags
  // are only sent once every table entry they would read holds a defined value.
  bit centre_set [N_CLUSTERS][N_DIMS];
  bit radius_set [N_CLUSTERS];

  bit no_stall    = 1'b0;
  int idle_cycles = 0;
  int items_sent  = 0;

  nearest_centroid_radius_match_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both monitors sample at the rising edge, before any nonblocking update of that edge,
  // so a transaction is seen exactly when the block sees it.
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note_item(item);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // The receiver stalls at random, except during the calm stretch of the random part.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // Any accepted transaction or register write proves progress; a long silence means the
  // block has hung.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("nearest_centroid_radius_match_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request transaction and returns at the edge where it is accepted. A gap
  // of random length may come first; valid stays high between back-to-back transactions.
  task automatic send_item(input ncrm_in_t it);
    if (!no_stall && $urandom_range(99) < STALL_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < STALL_PCT) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (it.req_type != REQ_UNUSED) items_sent++;
  endtask

  // Lowers valid, waits for every expected result, then lets in-flight work finish so that
  // a register write cannot land while the block is busy.
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle. Unused upper data bits are sometimes
  // random, since the registers keep only their low bits.
  task automatic set_register(input logic idx, input int field);
    logic [31:0] word;
    word = ($urandom_range(1) == 1) ? $urandom() : 32'd0;
    if (idx == REG_DIMS) begin
      word[5:0] = field[5:0];
    end else begin
      word[6:0] = field[6:0];
    end
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, word);
  endtask

  task automatic configure(input int dims, input int clusters);
    set_register(REG_DIMS, dims);
    set_register(REG_CLUSTERS, clusters);
  endtask

  // Fields that a request type does not use are left random so every payload bit toggles.
  function automatic ncrm_in_t noise_fields();
    ncrm_in_t it;
    it.req_type      = 2'($urandom());
    it.cluster_index = 6'($urandom());
    it.coord_index   = 5'($urandom());
    it.coord_value   = 16'($urandom());
    it.radius_sq     = {16'($urandom()), 32'($urandom())};
    it.point_id      = $urandom();
    it.last          = 1'($urandom());
    return it;
  endfunction

  // Coordinates favor the extremes and a few coarse values, which makes equal distances
  // and therefore ties between clusters common.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(3) << 14);
      default: return 16'($urandom());
    endcase
  endfunction

  // Radii are mostly near typical distances so both outcomes of the radius test occur.
  function automatic logic [47:0] pick_radius();
    case ($urandom_range(5))
      0: return '0;
      1: return {48{1'b1}};
      2, 3: return {13'd0, 3'($urandom()), 32'($urandom())};
      default: return {16'($urandom()), 32'($urandom())};
    endcase
  endfunction

  task automatic load_centre(input int c, input int co, input logic [15:0] val);
    ncrm_in_t it;
    it               = noise_fields();
    it.req_type      = REQ_CENTRE;
    it.cluster_index = 6'(c);
    it.coord_index   = 5'(co);
    it.coord_value   = val;
    send_item(it);
    centre_set[c][co] = 1'b1;
  endtask

  task automatic load_radius(input int c, input logic [47:0] r);
    ncrm_in_t it;
    it               = noise_fields();
    it.req_type      = REQ_RADIUS;
    it.cluster_index = 6'(c);
    it.radius_sq     = r;
    send_item(it);
    radius_set[c] = 1'b1;
  endtask

  // A coordinate inside the active dimensions reads that centre coordinate of every
  // active cluster; load whichever of those are still undefined.
  task automatic fill_centres(input int co);
    int c;
    if (co < sb.active_dims()) begin
      for (c = 0; c < sb.active_clusters(); c++) begin
        if (!centre_set[c][co]) load_centre(c, co, pick_coord());
      end
    end
  endtask

  // The winner's radius is read only when some cluster is found, which needs at least
  // one active dimension.
  task automatic fill_radii();
    int c;
    if (sb.active_dims() > 0) begin
      for (c = 0; c < sb.active_clusters(); c++) begin
        if (!radius_set[c]) load_radius(c, pick_radius());
      end
    end
  endtask

  task automatic send_coord(input int co, input logic [15:0] val, input logic [31:0] pid,
                            input bit fin);
    ncrm_in_t it;
    fill_centres(co);
    if (fin) fill_radii();
    it             = noise_fields();
    it.req_type    = REQ_POINT;
    it.coord_index = 5'(co);
    it.coord_value = val;
    it.point_id    = pid;
    it.last        = fin;
    send_item(it);
  endtask

  task automatic send_unused();
    ncrm_in_t it;
    it          = noise_fields();
    it.req_type = REQ_UNUSED;
    send_item(it);
  endtask

  // Stray traffic: dropped requests and table rewrites anywhere in the tables.
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_unused();
      1: load_centre($urandom_range(N_CLUSTERS - 1), $urandom_range(N_DIMS - 1), pick_coord());
      default: load_radius($urandom_range(N_CLUSTERS - 1), pick_radius());
    endcase
  endtask

  // One point of random length. Most coordinates fall in the first span dimensions; some
  // lie beyond the active dimensions and only count for their last flag.
  task automatic random_point(input int span);
    int          n;
    int          k;
    int          co;
    int          nd;
    logic [31:0] pid;
    nd  = sb.active_dims();
    n   = $urandom_range(span + 2, 1);
    pid = $urandom();
    for (k = 0; k < n; k++) begin
      if (span > 0 && (nd >= N_DIMS || $urandom_range(9) != 0)) begin
        co = $urandom_range(span - 1);
      end else begin
        co = $urandom_range(N_DIMS - 1, nd);
      end
      if ($urandom_range(11) == 0) send_noise();
      send_coord(co, pick_coord(), ($urandom_range(9) == 0) ? $urandom() : pid, k == n - 1);
    end
  endtask

  initial begin
    int random_target;
    int phase_points;
    int dims;
    int clusters;
    int span;
    int p;

    sb         = new();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, one cluster over 22 dimensions. A point sitting on its centre gives
    // distance zero against radius zero, which is the boundary of the radius test.
    load_centre(0, 0, 16'h0000);
    load_radius(0, '0);
    send_coord(0, 16'h0000, 32'h0000_0000, 1'b1);
    // Extreme values, the top active dimension, and a last flag on a coordinate past the
    // active dimensions.
    send_coord(0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_coord(21, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_coord(31, 16'h1234, 32'hFFFF_FFFF, 1'b1);
    send_unused();
    drain();

    // One dimension, two clusters: an exact tie goes to the lower index, a far point is
    // not found, and a point next to cluster one picks it.
    configure(1, 2);
    load_centre(0, 0, 16'h8000);
    load_centre(1, 0, 16'h8000);
    load_radius(0, {48{1'b1}});
    load_radius(1, 48'd0);
    send_coord(0, 16'h8000, 32'h0000_0001, 1'b1);
    load_centre(0, 0, 16'h0000);
    load_centre(1, 0, 16'h0000);
    send_coord(0, 16'hFFFF, 32'h0000_0002, 1'b0);
    send_coord(0, 16'hFFFF, 32'h0000_0002, 1'b1);
    load_centre(0, 0, 16'hFFFF);
    send_coord(0, 16'h0000, 32'h0000_0003, 1'b1);
    drain();

    // No active dimension, with the cluster count written above its limit.
    configure(0, 127);
    send_coord(0, 16'hFFFF, 32'h0000_0004, 1'b1);
    drain();

    // No active cluster, with the dimension count written above its limit.
    configure(63, 0);
    send_coord(5, 16'h0000, 32'h0000_0005, 1'b1);
    drain();

    // Random phases, each with its own register settings. Wide cluster tables make every
    // coordinate slow, so those phases use few dimensions and few points.
    random_target = items_sent + RANDOM_ITEMS;
    p = 0;
    while (items_sent < random_target) begin
      case (p)
        0: begin
          dims     = 32;
          clusters = 64;
        end
        1: begin
          dims     = 32;
          clusters = 1;
        end
        2: begin
          dims     = 1;
          clusters = 64;
        end
        default: begin
          case ($urandom_range(9))
            0: dims = 0;
            1: dims = 32;
            2: dims = $urandom_range(63, 33);
            3: dims = 1;
            default: dims = $urandom_range(24, 2);
          endcase
          case ($urandom_range(9))
            0: clusters = 0;
            1: clusters = 64;
            2: clusters = $urandom_range(127, 65);
            3: clusters = 1;
            default: clusters = $urandom_range(8, 2);
          endcase
        end
      endcase
      configure(dims, clusters);
      if (sb.active_clusters() > 16) begin
        span         = (sb.active_dims() < 3) ? sb.active_dims() : 3;
        phase_points = 6;
      end else begin
        span         = (sb.active_dims() < 10) ? sb.active_dims() : 10;
        phase_points = 15;
      end
      // A calm stretch in the middle of the random part runs with no idling on either side.
      no_stall = (items_sent >= random_target - RANDOM_ITEMS + 200) &&
                 (items_sent < random_target - RANDOM_ITEMS + 350);
      repeat (phase_points) begin
        if ($urandom_range(5) == 0) send_noise();
        random_point(span);
      end
      drain();
      p++;
    end

    no_stall = 1'b0;
    drain();
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("nearest_centroid_radius_match_top: match");
    end else begin
      $display("nearest_centroid_radius_match_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/ncrm_pkg.sv
sv/ncrm_ram.sv
sv/ncrm_mac.sv
sv/nearest_centroid_radius_match_top.sv
bench/ncrm_bench_pkg.sv
bench/nearest_centroid_radius_match_top_test.sv
